FILE: rtl/core/lz78_phrase_encoder_defines.svh
// assertion macros for the lz78 phrase encoder
// expects clk and arst_n in scope at the point of use
`ifndef LZ78_PHRASE_ENCODER_DEFINES_SVH
`define LZ78_PHRASE_ENCODER_DEFINES_SVH

// condition holds at every edge out of reset
`define LZPE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LZPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/lzpe_pkg.sv
// shared types and constants of the lz78 phrase encoder
// no dependencies
`default_nettype none

package lzpe_pkg;

	// dictionary size used when the top level is not overridden
	localparam int DICT_SIZE_DEF = 4096;

	// result field widths
	localparam int CODE_FIELD_W  = 12;
	localparam int WIDTH_FIELD_W = 4;
	localparam int BYTE_W        = 8;

	// reserved codes and end marker
	localparam int FIRST_CODE = 3;
	localparam int END_MARK   = 2;
	localparam int END_WIDTH  = 8;

	// token kinds
	localparam logic TOKEN_PHRASE = 1'b0;
	localparam logic TOKEN_END    = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT,
		ST_ENTRY,
		ST_TOKEN,
		ST_MARK
	} lzpe_state_t;

	// memory controls from the sequencer to the dictionary
	typedef struct packed {
		logic slot_rd;
		logic ent_rd;
		logic wr;
	} dict_ctl_t;

	// one result item
	typedef struct packed {
		logic                     token_kind;
		logic [CODE_FIELD_W-1:0]  phrase_code;
		logic [WIDTH_FIELD_W-1:0] code_width;
		logic [BYTE_W-1:0]        literal_byte;
		logic                     block_end;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/lzpe_ifs.sv
// valid/ready channel interfaces for source bytes and tokens
// depends on lzpe_pkg
`default_nettype none

interface lzpe_byte_if import lzpe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface lzpe_token_if import lzpe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     token_kind;
	logic [CODE_FIELD_W-1:0]  phrase_code;
	logic [WIDTH_FIELD_W-1:0] code_width;
	logic [BYTE_W-1:0]        literal_byte;
	logic                     block_end;

	modport source (output valid, output token_kind, output phrase_code, output code_width,
		output literal_byte, output block_end, input ready);
	modport sink   (input valid, input token_kind, input phrase_code, input code_width,
		input literal_byte, input block_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lzpe_dict.sv
// dictionary storage: hash slot memory and code entry memory
// depends on lzpe_pkg; both memories have registered reads
`default_nettype none

module lzpe_dict import lzpe_pkg::*; #(
	parameter int DICT_SIZE = DICT_SIZE_DEF,
	parameter int CW        = $clog2(DICT_SIZE),
	parameter int TB        = CW + 1
) (
	input  wire logic          clk,
	input  wire dict_ctl_t     ctl,
	input  wire logic [TB-1:0] slot_raddr,
	input  wire logic [CW-1:0] ent_raddr,
	input  wire logic [TB-1:0] wr_slot,
	input  wire logic [CW-1:0] wr_code,
	input  wire logic [CW-1:0] wr_parent,
	input  wire logic [7:0]    wr_byte,
	output logic      [CW-1:0] slot_rdata,
	output logic      [CW-1:0] ent_parent,
	output logic      [7:0]    ent_byte,
	output logic      [TB-1:0] ent_slot
);

	localparam int EW = CW + 8 + TB;

	// slot memory holds a code per hash slot, entry memory holds parent, byte, home slot
	logic [CW-1:0] slot_mem [2**TB];
	logic [EW-1:0] ent_mem  [DICT_SIZE];
	logic [EW-1:0] ent_rd_q;

	// slot memory port
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			slot_mem[wr_slot] <= wr_code;
		end
		if (ctl.slot_rd) begin
			slot_rdata <= slot_mem[slot_raddr];
		end
	end

	// entry memory port
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			ent_mem[wr_code] <= {wr_parent, wr_byte, wr_slot};
		end
		if (ctl.ent_rd) begin
			ent_rd_q <= ent_mem[ent_raddr];
		end
	end

	assign ent_parent = ent_rd_q[EW-1 -: CW];
	assign ent_byte   = ent_rd_q[TB +: 8];
	assign ent_slot   = ent_rd_q[TB-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/lzpe_out.sv
// output register stage for result items
// depends on lzpe_pkg and lzpe_token_if
`default_nettype none

module lzpe_out import lzpe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire result_t  res,
	output logic          free,
	lzpe_token_if.source  tokens
);

	logic    valid_q;
	result_t res_q;

	// held result leaves on a transfer, a new one may load in the same cycle
	assign free = !valid_q || tokens.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tokens.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign tokens.valid        = valid_q;
	assign tokens.token_kind   = res_q.token_kind;
	assign tokens.phrase_code  = res_q.phrase_code;
	assign tokens.code_width   = res_q.code_width;
	assign tokens.literal_byte = res_q.literal_byte;
	assign tokens.block_end    = res_q.block_end;

endmodule

`default_nettype wire

FILE: rtl/core/lz78_phrase_encoder.sv
// lz78 phrase encoder: source bytes in, phrase tokens out
//
// source_bytes carries one byte per transfer with final_byte marking the last
// byte of a block. tokens carries result items: a phrase token (matched code,
// code width, literal byte) whenever a byte cannot extend the match, and after
// the last byte of a block a second item, the end marker, with block_end set.
// A byte that extends the match gives no result.
// The dictionary is a hash table with linear probing: each probe reads the slot
// memory, then the entry memory of the code found there.
// A byte passes through the slot and entry states, and again for each extra probe,
// then through the token state when it gives a token and the mark state for the
// end marker; a last byte skips the lookup once the dictionary is full. A token
// is valid on the output from the output register once the token state loads it.
// Reset returns the match to the root and the next code to 3; the memories
// are not cleared, since a slot is only trusted when its code is below the
// next free code and that code's entry points back at the slot.
// The output register lets a new byte be taken while a token waits; when the
// receiver stalls, the sequencer holds in its token or mark state until the register
// frees, and input is then held off.
// depends on lzpe_pkg, lzpe_ifs, lzpe_dict, lzpe_out
`default_nettype none
`include "lz78_phrase_encoder_defines.svh"

module lz78_phrase_encoder import lzpe_pkg::*; #(
	parameter int DICT_SIZE = DICT_SIZE_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lzpe_byte_if.sink    source_bytes,
	lzpe_token_if.source tokens
);

	localparam int CW  = $clog2(DICT_SIZE);
	localparam int NW  = CW + 1;
	localparam int TB  = CW + 1;
	localparam int WW  = $clog2(CW + 1);
	localparam int KW  = CW + 8;
	localparam int NCH = (KW + TB - 1) / TB;

	lzpe_state_t state_q, state_d;

	logic [CW-1:0] match_q;
	logic [NW-1:0] nfc_q;
	logic [WW-1:0] width_q;
	logic [7:0]    byte_q;
	logic          last_q;
	logic [TB-1:0] slot_q;
	logic [CW-1:0] cand_q;

	dict_ctl_t     dict_ctl;
	logic [TB-1:0] slot_raddr;
	logic [CW-1:0] slot_rdata;
	logic [CW-1:0] ent_parent;
	logic [7:0]    ent_byte;
	logic [TB-1:0] ent_slot;

	logic          accept;
	logic          full;
	logic          occupied;
	logic          keymatch;
	logic          hit;
	logic          probe_next;
	logic          out_load;
	logic          out_free;
	result_t       res;
	logic [31:0]   code_wide;
	logic [31:0]   width_wide;

	// fold the (parent, byte) key down to a slot index
	function automatic logic [TB-1:0] hash_key(input logic [CW-1:0] p, input logic [7:0] b);
		logic [NCH*TB-1:0] key;
		logic [TB-1:0]     h;
		key = '0;
		key[KW-1:0] = {p, b};
		h = '0;
		for (int i = 0; i < NCH; i++) begin
			h ^= key[i*TB +: TB];
		end
		return h;
	endfunction

	// a code is live when it has been assigned
	function automatic logic code_live(input logic [CW-1:0] c, input logic [NW-1:0] nfc);
		return (NW'(c) >= NW'(FIRST_CODE)) && (NW'(c) < nfc);
	endfunction

	assign source_bytes.ready = (state_q == ST_IDLE);
	assign accept   = source_bytes.valid && source_bytes.ready;
	assign full     = (nfc_q == NW'(DICT_SIZE));
	assign occupied = code_live(cand_q, nfc_q) && (ent_slot == slot_q);
	assign keymatch = (ent_parent == match_q) && (ent_byte == byte_q);

	// token field views, masked to the field widths
	assign code_wide  = 32'(match_q);
	assign width_wide = 32'(width_q);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d    = state_q;
		dict_ctl   = '0;
		slot_raddr = slot_q + TB'(1);
		hit        = 1'b0;
		probe_next = 1'b0;
		out_load   = 1'b0;
		res        = '0;
		unique case (state_q)
			ST_IDLE: begin
				slot_raddr = hash_key(match_q, source_bytes.data_byte);
				if (accept) begin
					dict_ctl.slot_rd = 1'b1;
					state_d = (source_bytes.final_byte && full) ? ST_TOKEN : ST_SLOT;
				end
			end
			ST_SLOT: begin
				dict_ctl.ent_rd = code_live(slot_rdata, nfc_q);
				state_d = ST_ENTRY;
			end
			ST_ENTRY: begin
				if (occupied && keymatch && !last_q) begin
					hit = 1'b1;
					state_d = ST_IDLE;
				end else if (occupied) begin
					probe_next = 1'b1;
					dict_ctl.slot_rd = 1'b1;
					state_d = ST_SLOT;
				end else begin
					state_d = ST_TOKEN;
				end
			end
			ST_TOKEN: begin
				res.token_kind   = TOKEN_PHRASE;
				res.phrase_code  = code_wide[CODE_FIELD_W-1:0];
				res.code_width   = width_wide[WIDTH_FIELD_W-1:0];
				res.literal_byte = byte_q;
				res.block_end    = 1'b0;
				if (out_free) begin
					out_load    = 1'b1;
					dict_ctl.wr = !full;
					state_d = last_q ? ST_MARK : ST_IDLE;
				end
			end
			ST_MARK: begin
				res.token_kind   = TOKEN_END;
				res.phrase_code  = '0;
				res.code_width   = WIDTH_FIELD_W'(END_WIDTH);
				res.literal_byte = BYTE_W'(END_MARK);
				res.block_end    = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// match node, next free code and current code width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			nfc_q   <= NW'(FIRST_CODE);
			width_q <= WW'(2);
		end else begin
			if (hit) begin
				match_q <= cand_q;
			end
			if (state_q == ST_TOKEN && out_free) begin
				match_q <= '0;
			end
			if (dict_ctl.wr) begin
				nfc_q <= nfc_q + NW'(1);
				// highest code reaches a power of two
				if ((nfc_q & (nfc_q - NW'(1))) == '0) begin
					width_q <= width_q + WW'(1);
				end
			end
		end
	end

	// per-byte working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= source_bytes.data_byte;
			last_q <= source_bytes.final_byte;
			slot_q <= slot_raddr;
		end else if (probe_next) begin
			slot_q <= slot_raddr;
		end
		if (state_q == ST_SLOT) begin
			cand_q <= slot_rdata;
		end
	end

	lzpe_dict #(
		.DICT_SIZE (DICT_SIZE),
		.CW        (CW),
		.TB        (TB)
	) u_dict (
		.clk        (clk),
		.ctl        (dict_ctl),
		.slot_raddr (slot_raddr),
		.ent_raddr  (slot_rdata),
		.wr_slot    (slot_q),
		.wr_code    (nfc_q[CW-1:0]),
		.wr_parent  (match_q),
		.wr_byte    (byte_q),
		.slot_rdata (slot_rdata),
		.ent_parent (ent_parent),
		.ent_byte   (ent_byte),
		.ent_slot   (ent_slot)
	);

	lzpe_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.res    (res),
		.free   (out_free),
		.tokens (tokens)
	);

	// checks
	`LZPE_ASSERT_ALWAYS(a_code_range, (nfc_q >= NW'(FIRST_CODE)) && (nfc_q <= NW'(DICT_SIZE)), "next free code out of range")
	`LZPE_ASSERT_NEXT(a_insert_step, dict_ctl.wr, nfc_q == $past(nfc_q) + NW'(1), "insert did not advance next free code")
	`LZPE_ASSERT_NEXT(a_hit_moves, hit, (match_q != '0) && code_live(match_q, nfc_q), "match moved to a dead code")

endmodule

`default_nettype wire
